// ===== rtl/ebalu_pkg.sv =====
package ebalu_pkg;

   // operation codes of the request channel
   typedef enum logic [4:0] {
      OP_ADD     = 5'd0,
      OP_ADC     = 5'd1,
      OP_SUB     = 5'd2,
      OP_SBC     = 5'd3,
      OP_AND     = 5'd4,
      OP_XOR     = 5'd5,
      OP_OR      = 5'd6,
      OP_CP      = 5'd7,
      OP_INC8    = 5'd8,
      OP_DEC8    = 5'd9,
      OP_DAA     = 5'd10,
      OP_CPL     = 5'd11,
      OP_SCF     = 5'd12,
      OP_CCF     = 5'd13,
      OP_RLCA    = 5'd14,
      OP_RRCA    = 5'd15,
      OP_RLA     = 5'd16,
      OP_RRA     = 5'd17,
      OP_ADD16   = 5'd18,
      OP_ADD_SP  = 5'd19,
      OP_CB      = 5'd20,
      OP_INC16   = 5'd21,
      OP_DEC16   = 5'd22
   } op_type;

   // cb opcode groups (bits 7:6)
   typedef enum logic [1:0] {
      CB_SHIFT = 2'd0,
      CB_BIT   = 2'd1,
      CB_RES   = 2'd2,
      CB_SET   = 2'd3
   } cb_group_type;

   // cb shift and rotate kinds (bits 5:3 within the shift group)
   typedef enum logic [2:0] {
      CB_RLC  = 3'd0,
      CB_RRC  = 3'd1,
      CB_RL   = 3'd2,
      CB_RR   = 3'd3,
      CB_SLA  = 3'd4,
      CB_SRA  = 3'd5,
      CB_SWAP = 3'd6,
      CB_SRL  = 3'd7
   } cb_shift_type;

   // flag bit positions
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // decimal adjust constants
   localparam logic [7:0] DAA_LIMIT  = 8'h99;
   localparam logic [7:0] DAA_ADJ_HI = 8'h60;
   localparam logic [7:0] DAA_ADJ_LO = 8'h06;
   localparam logic [3:0] DAA_DIGIT_MAX = 4'h9;

   typedef struct packed {
      logic [4:0]  op;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [3:0]  flags_in;
   } req_data_type;

   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags_out;
      logic        write_back;
   } rsp_data_type;

endpackage

// ===== rtl/ebalu_if.sv =====
interface ebalu_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  op;
   logic [15:0] operand_a;
   logic [15:0] operand_b;
   logic [3:0]  flags_in;

   modport source (output valid, output op, output operand_a, output operand_b,
                   output flags_in, input ready);
   modport sink (input valid, input op, input operand_a, input operand_b,
                 input flags_in, output ready);
endinterface

interface ebalu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result;
   logic [3:0]  flags_out;
   logic        write_back;

   modport source (output valid, output result, output flags_out, output write_back,
                   input ready);
   modport sink (input valid, input result, input flags_out, input write_back,
                 output ready);
endinterface

// ===== rtl/eight_bit_cpu_alu_with_flags_unit.sv =====
// Flag-producing ALU of an 8-bit handheld console CPU. Each request beat carries an
// operation code, two 16-bit operands and the Z/N/H/C flags (bit3..bit0); each
// one gives exactly one response beat with the result, the new flags and a
// write-back bit. The block is a two-register pipeline: a request register,
// one pass of adders, shifters and selects, and a response register. An
// accepted request passes through the request register and then the response
// register before it appears as a response beat, and a new request is taken in
// every cycle while the response side keeps up. When the response is stalled
// the request register still fills, so one more beat is taken before
// req_ch.ready drops. There is no state beyond the pipeline and nothing to
// configure.
module eight_bit_cpu_alu_with_flags_unit (
   input  logic          clock,
   input  logic          reset,
   ebalu_req_if.sink     req_ch,
   ebalu_rsp_if.source   rsp_ch
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   ebalu_pkg::req_data_type in_data_ff;
   ebalu_pkg::req_data_type req_data;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   ebalu_pkg::rsp_data_type out_data_ff;
   ebalu_pkg::rsp_data_type core_data;
   logic                    out_open;
   logic                    req_take;

   // handshake control
   assign out_open     = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || out_open;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !out_open);
   assign out_valid_in = out_open ? in_valid_ff : out_valid_ff;

   // request payload
   assign req_data.op        = req_ch.op;
   assign req_data.operand_a = req_ch.operand_a;
   assign req_data.operand_b = req_ch.operand_b;
   assign req_data.flags_in  = req_ch.flags_in;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   // compute
   ebalu_core u_core (
      .req_data (in_data_ff),
      .rsp_data (core_data)
   );

   // response register
   always_ff @(posedge clock) begin
      if (out_open && in_valid_ff) begin
         out_data_ff <= core_data;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.result     = out_data_ff.result;
   assign rsp_ch.flags_out  = out_data_ff.flags_out;
   assign rsp_ch.write_back = out_data_ff.write_back;

`ifndef SYNTHESIS
   // an accepted beat lands in the request register
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted request beat not held in request register");

   // a beat moving forward lands in the response register
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_open) |=> out_valid_ff)
      else $error("request beat lost on its way to the response register");

   // a blocked beat stays in the request register
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_open) |=> in_valid_ff)
      else $error("blocked request beat dropped");
`endif

endmodule

// ===== rtl/ebalu_core.sv =====
module ebalu_core (
   input  ebalu_pkg::req_data_type req_data,
   output ebalu_pkg::rsp_data_type rsp_data
);

   logic [7:0]  a;
   logic [7:0]  b;
   logic [15:0] a16;
   logic [15:0] b16;
   logic        fz;
   logic        fn;
   logic        fh;
   logic        fc;
   logic        cin_add;
   logic        cin_sub;

   logic [8:0]  add_sum;
   logic [4:0]  add_half;
   logic [8:0]  sub_diff;
   logic [4:0]  sub_half;
   logic [7:0]  inc_val;
   logic [7:0]  dec_val;
   logic        daa_lo;
   logic        daa_hi;
   logic [7:0]  daa_adj;
   logic [7:0]  daa_val;
   logic [16:0] add16_sum;
   logic [12:0] add16_half;
   logic [15:0] sp_sum;
   logic [4:0]  sp_half;
   logic [8:0]  sp_low;

   // cb unit signals
   logic [2:0]  cb_sel;
   logic [1:0]  cb_grp;
   logic [7:0]  cb_mask;
   logic [7:0]  cb_shift_val;
   logic        cb_shift_cy;
   logic [7:0]  cb_val;
   logic [3:0]  cb_flags;
   logic        cb_wb;

   // operand and flag unpacking
   assign a16 = req_data.operand_a;
   assign b16 = req_data.operand_b;
   assign a   = a16[7:0];
   assign b   = b16[7:0];
   assign fz  = req_data.flags_in[ebalu_pkg::FLAG_Z];
   assign fn  = req_data.flags_in[ebalu_pkg::FLAG_N];
   assign fh  = req_data.flags_in[ebalu_pkg::FLAG_H];
   assign fc  = req_data.flags_in[ebalu_pkg::FLAG_C];

   // carry in only for the with-carry forms
   assign cin_add = (ebalu_pkg::op_type'(req_data.op) == ebalu_pkg::OP_ADC) ? fc : 1'b0;
   assign cin_sub = (ebalu_pkg::op_type'(req_data.op) == ebalu_pkg::OP_SBC) ? fc : 1'b0;

   // 8-bit adder and subtractor with half carries
   assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, cin_add};
   assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_add};
   assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, cin_sub};
   assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_sub};
   assign inc_val  = a + 8'd1;
   assign dec_val  = a - 8'd1;

   // decimal adjust
   assign daa_lo  = fh || (!fn && (a[3:0] > ebalu_pkg::DAA_DIGIT_MAX));
   assign daa_hi  = fc || (!fn && (a > ebalu_pkg::DAA_LIMIT));
   assign daa_adj = (daa_lo ? ebalu_pkg::DAA_ADJ_LO : 8'h00) |
                    (daa_hi ? ebalu_pkg::DAA_ADJ_HI : 8'h00);
   assign daa_val = fn ? (a - daa_adj) : (a + daa_adj);

   // 16-bit add and stack pointer plus signed byte
   assign add16_sum  = {1'b0, a16} + {1'b0, b16};
   assign add16_half = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
   assign sp_sum     = a16 + {{8{b[7]}}, b};
   assign sp_half    = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
   assign sp_low     = {1'b0, a16[7:0]} + {1'b0, b};

   // cb prefix: shifts and rotates, bit test, reset, set
   assign cb_sel  = b[5:3];
   assign cb_grp  = b[7:6];
   assign cb_mask = 8'd1 << cb_sel;

   always_comb begin
      case (ebalu_pkg::cb_shift_type'(cb_sel))
         ebalu_pkg::CB_RLC: begin
            cb_shift_val = {a[6:0], a[7]};
            cb_shift_cy  = a[7];
         end
         ebalu_pkg::CB_RRC: begin
            cb_shift_val = {a[0], a[7:1]};
            cb_shift_cy  = a[0];
         end
         ebalu_pkg::CB_RL: begin
            cb_shift_val = {a[6:0], fc};
            cb_shift_cy  = a[7];
         end
         ebalu_pkg::CB_RR: begin
            cb_shift_val = {fc, a[7:1]};
            cb_shift_cy  = a[0];
         end
         ebalu_pkg::CB_SLA: begin
            cb_shift_val = {a[6:0], 1'b0};
            cb_shift_cy  = a[7];
         end
         ebalu_pkg::CB_SRA: begin
            cb_shift_val = {a[7], a[7:1]};
            cb_shift_cy  = a[0];
         end
         ebalu_pkg::CB_SWAP: begin
            cb_shift_val = {a[3:0], a[7:4]};
            cb_shift_cy  = 1'b0;
         end
         default: begin
            cb_shift_val = {1'b0, a[7:1]};
            cb_shift_cy  = a[0];
         end
      endcase
   end

   always_comb begin
      cb_wb = 1'b1;
      unique case (ebalu_pkg::cb_group_type'(cb_grp))
         ebalu_pkg::CB_BIT: begin
            cb_val   = a;
            cb_flags = {~|(a & cb_mask), 1'b0, 1'b1, fc};
            cb_wb    = 1'b0;
         end
         ebalu_pkg::CB_RES: begin
            cb_val   = a & ~cb_mask;
            cb_flags = req_data.flags_in;
         end
         ebalu_pkg::CB_SET: begin
            cb_val   = a | cb_mask;
            cb_flags = req_data.flags_in;
         end
         default: begin
            cb_val   = cb_shift_val;
            cb_flags = {~|cb_shift_val, 1'b0, 1'b0, cb_shift_cy};
         end
      endcase
   end

   // result and flag select by operation
   always_comb begin
      rsp_data.result     = {8'h00, a};
      rsp_data.flags_out  = req_data.flags_in;
      rsp_data.write_back = 1'b1;
      unique case (ebalu_pkg::op_type'(req_data.op))
         ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC: begin
            rsp_data.result    = {8'h00, add_sum[7:0]};
            rsp_data.flags_out = {~|add_sum[7:0], 1'b0, add_half[4], add_sum[8]};
         end
         ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC: begin
            rsp_data.result    = {8'h00, sub_diff[7:0]};
            rsp_data.flags_out = {~|sub_diff[7:0], 1'b1, sub_half[4], sub_diff[8]};
         end
         ebalu_pkg::OP_CP: begin
            rsp_data.flags_out  = {~|sub_diff[7:0], 1'b1, sub_half[4], sub_diff[8]};
            rsp_data.write_back = 1'b0;
         end
         ebalu_pkg::OP_AND: begin
            rsp_data.result    = {8'h00, a & b};
            rsp_data.flags_out = {~|(a & b), 1'b0, 1'b1, 1'b0};
         end
         ebalu_pkg::OP_XOR: begin
            rsp_data.result    = {8'h00, a ^ b};
            rsp_data.flags_out = {~|(a ^ b), 1'b0, 1'b0, 1'b0};
         end
         ebalu_pkg::OP_OR: begin
            rsp_data.result    = {8'h00, a | b};
            rsp_data.flags_out = {~|(a | b), 1'b0, 1'b0, 1'b0};
         end
         ebalu_pkg::OP_INC8: begin
            rsp_data.result    = {8'h00, inc_val};
            rsp_data.flags_out = {~|inc_val, 1'b0, ~|inc_val[3:0], fc};
         end
         ebalu_pkg::OP_DEC8: begin
            rsp_data.result    = {8'h00, dec_val};
            rsp_data.flags_out = {~|dec_val, 1'b1, &dec_val[3:0], fc};
         end
         ebalu_pkg::OP_DAA: begin
            rsp_data.result    = {8'h00, daa_val};
            rsp_data.flags_out = {~|daa_val, fn, 1'b0, daa_hi};
         end
         ebalu_pkg::OP_CPL: begin
            rsp_data.result    = {8'h00, ~a};
            rsp_data.flags_out = {fz, 1'b1, 1'b1, fc};
         end
         ebalu_pkg::OP_SCF: begin
            rsp_data.flags_out  = {fz, 1'b0, 1'b0, 1'b1};
            rsp_data.write_back = 1'b0;
         end
         ebalu_pkg::OP_CCF: begin
            rsp_data.flags_out  = {fz, 1'b0, 1'b0, ~fc};
            rsp_data.write_back = 1'b0;
         end
         ebalu_pkg::OP_RLCA: begin
            rsp_data.result    = {8'h00, a[6:0], a[7]};
            rsp_data.flags_out = {1'b0, 1'b0, 1'b0, a[7]};
         end
         ebalu_pkg::OP_RRCA: begin
            rsp_data.result    = {8'h00, a[0], a[7:1]};
            rsp_data.flags_out = {1'b0, 1'b0, 1'b0, a[0]};
         end
         ebalu_pkg::OP_RLA: begin
            rsp_data.result    = {8'h00, a[6:0], fc};
            rsp_data.flags_out = {1'b0, 1'b0, 1'b0, a[7]};
         end
         ebalu_pkg::OP_RRA: begin
            rsp_data.result    = {8'h00, fc, a[7:1]};
            rsp_data.flags_out = {1'b0, 1'b0, 1'b0, a[0]};
         end
         ebalu_pkg::OP_ADD16: begin
            rsp_data.result    = add16_sum[15:0];
            rsp_data.flags_out = {fz, 1'b0, add16_half[12], add16_sum[16]};
         end
         ebalu_pkg::OP_ADD_SP: begin
            rsp_data.result    = sp_sum;
            rsp_data.flags_out = {1'b0, 1'b0, sp_half[4], sp_low[8]};
         end
         ebalu_pkg::OP_CB: begin
            rsp_data.result     = {8'h00, cb_val};
            rsp_data.flags_out  = cb_flags;
            rsp_data.write_back = cb_wb;
         end
         ebalu_pkg::OP_INC16: begin
            rsp_data.result = a16 + 16'd1;
         end
         ebalu_pkg::OP_DEC16: begin
            rsp_data.result = a16 - 16'd1;
         end
         default: begin
            rsp_data.result     = 16'h0000;
            rsp_data.write_back = 1'b0;
         end
      endcase
   end

endmodule

// ===== tb/sv/eight_bit_cpu_alu_with_flags_unit_tb.sv =====
`timescale 1ns / 1ps

module eight_bit_cpu_alu_with_flags_unit_tb;
   import ebalu_pkg::*;

   // idle profile boundary (in accepted request beats), random item count, drain wait
   localparam int PHASE_LEN   = 240;
   localparam int RANDOM_LEN  = 700;
   localparam int DRAIN_WAIT  = 8;

   // opcodes outside the defined set
   localparam logic [4:0] OP_UNDEF_LO = 5'd23;
   localparam logic [4:0] OP_UNDEF_HI = 5'd31;

   logic clock = 1'b0;
   logic reset;

   ebalu_req_if req_bus ();
   ebalu_rsp_if rsp_bus ();

   eight_bit_cpu_alu_with_flags_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   req_data_type pending_req_q[$];
   rsp_data_type expected_rsp_q[$];
   int accepted_count = 0;
   int total_items = 0;
   int error_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // expected result of one alu operation
   function automatic rsp_data_type alu_expect(input req_data_type rq);
      rsp_data_type rs;
      int a, b, a16, b16, r, t, adj, cin, mask, sel, e8;
      logic fz, fn, fh, fc, h, cy, hi_adj;
      a   = int'(rq.operand_a[7:0]);
      b   = int'(rq.operand_b[7:0]);
      a16 = int'(rq.operand_a);
      b16 = int'(rq.operand_b);
      fz  = rq.flags_in[FLAG_Z];
      fn  = rq.flags_in[FLAG_N];
      fh  = rq.flags_in[FLAG_H];
      fc  = rq.flags_in[FLAG_C];
      cin = int'(fc);
      r   = 0;
      rs.flags_out  = rq.flags_in;
      rs.write_back = 1'b1;
      case (rq.op)
         OP_ADD, OP_ADC: begin
            if (rq.op == OP_ADD) cin = 0;
            t = a + b + cin;
            r = t & 'hFF;
            h = ((a & 'hF) + (b & 'hF) + cin) > 'hF;
            rs.flags_out = {r == 0, 1'b0, h, t > 'hFF};
         end
         OP_SUB, OP_SBC, OP_CP: begin
            if (rq.op != OP_SBC) cin = 0;
            r = (a - b - cin) & 'hFF;
            rs.flags_out = {r == 0, 1'b1, (a & 'hF) < (b & 'hF) + cin, a < b + cin};
            // compare leaves the accumulator alone
            if (rq.op == OP_CP) begin
               r = a;
               rs.write_back = 1'b0;
            end
         end
         OP_AND: begin
            r = a & b;
            rs.flags_out = {r == 0, 1'b0, 1'b1, 1'b0};
         end
         OP_XOR: begin
            r = a ^ b;
            rs.flags_out = {r == 0, 3'b000};
         end
         OP_OR: begin
            r = a | b;
            rs.flags_out = {r == 0, 3'b000};
         end
         OP_INC8: begin
            r = (a + 1) & 'hFF;
            rs.flags_out = {r == 0, 1'b0, (r & 'hF) == 0, fc};
         end
         OP_DEC8: begin
            r = (a - 1) & 'hFF;
            rs.flags_out = {r == 0, 1'b1, (r & 'hF) == 'hF, fc};
         end
         OP_DAA: begin
            adj = 0;
            hi_adj = 1'b0;
            if (fh || (!fn && (a & 'hF) > 9)) adj = 'h06;
            if (fc || (!fn && a > 'h99)) begin
               adj = adj | 'h60;
               hi_adj = 1'b1;
            end
            r = (fn ? a - adj : a + adj) & 'hFF;
            rs.flags_out = {r == 0, fn, 1'b0, hi_adj};
         end
         OP_CPL: begin
            r = ~a & 'hFF;
            rs.flags_out = {fz, 1'b1, 1'b1, fc};
         end
         OP_SCF: begin
            r = a;
            rs.write_back = 1'b0;
            rs.flags_out = {fz, 1'b0, 1'b0, 1'b1};
         end
         OP_CCF: begin
            r = a;
            rs.write_back = 1'b0;
            rs.flags_out = {fz, 1'b0, 1'b0, ~fc};
         end
         OP_RLCA: begin
            r = ((a << 1) | (a >> 7)) & 'hFF;
            rs.flags_out = {3'b000, rq.operand_a[7]};
         end
         OP_RRCA: begin
            r = ((a >> 1) | (a << 7)) & 'hFF;
            rs.flags_out = {3'b000, rq.operand_a[0]};
         end
         OP_RLA: begin
            r = ((a << 1) | cin) & 'hFF;
            rs.flags_out = {3'b000, rq.operand_a[7]};
         end
         OP_RRA: begin
            r = (a >> 1) | (cin << 7);
            rs.flags_out = {3'b000, rq.operand_a[0]};
         end
         OP_ADD16: begin
            t = a16 + b16;
            r = t & 'hFFFF;
            h = ((a16 & 'hFFF) + (b16 & 'hFFF)) >= 'h1000;
            rs.flags_out = {fz, 1'b0, h, t >= 'h10000};
         end
         OP_ADD_SP: begin
            // e8 is sign-extended for the sum, flags come from the low byte
            e8 = rq.operand_b[7] ? (b | 'hFF00) : b;
            r = (a16 + e8) & 'hFFFF;
            h = ((a16 & 'hF) + (b & 'hF)) >= 'h10;
            rs.flags_out = {2'b00, h, ((a16 & 'hFF) + b) >= 'h100};
         end
         OP_CB: begin
            sel  = int'(rq.operand_b[5:3]);
            mask = 1 << sel;
            case (rq.operand_b[7:6])
               CB_BIT: begin
                  r = a;
                  rs.write_back = 1'b0;
                  rs.flags_out = {(a & mask) == 0, 1'b0, 1'b1, fc};
               end
               CB_RES: r = a & ~mask & 'hFF;
               CB_SET: r = (a | mask) & 'hFF;
               default: begin
                  cy = rq.operand_a[0];
                  case (rq.operand_b[5:3])
                     CB_RLC: begin
                        r = ((a << 1) | (a >> 7)) & 'hFF;
                        cy = rq.operand_a[7];
                     end
                     CB_RRC: r = ((a >> 1) | (a << 7)) & 'hFF;
                     CB_RL: begin
                        r = ((a << 1) | cin) & 'hFF;
                        cy = rq.operand_a[7];
                     end
                     CB_RR: r = (a >> 1) | (cin << 7);
                     CB_SLA: begin
                        r = (a << 1) & 'hFF;
                        cy = rq.operand_a[7];
                     end
                     CB_SRA: r = (a >> 1) | (a & 'h80);
                     CB_SWAP: begin
                        r = ((a >> 4) | (a << 4)) & 'hFF;
                        cy = 1'b0;
                     end
                     default: r = a >> 1;
                  endcase
                  rs.flags_out = {r == 0, 2'b00, cy};
               end
            endcase
         end
         OP_INC16: r = (a16 + 1) & 'hFFFF;
         OP_DEC16: r = (a16 - 1) & 'hFFFF;
         default: begin
            r = 0;
            rs.write_back = 1'b0;
         end
      endcase
      rs.result = r[15:0];
      return rs;
   endfunction

   function automatic int sender_gap_pct(input int n);
      if (n < PHASE_LEN) return 24;
      if (n < 2 * PHASE_LEN) return 78;
      return 0;
   endfunction

   function automatic int receiver_stall_pct(input int n);
      if (n < PHASE_LEN) return 78;
      if (n < 2 * PHASE_LEN) return 24;
      return 0;
   endfunction

   task automatic add_item(input logic [4:0] op, input logic [15:0] a, input logic [15:0] b,
                           input logic [3:0] f);
      req_data_type it;
      it.op = op;
      it.operand_a = a;
      it.operand_b = b;
      it.flags_in = f;
      pending_req_q.push_back(it);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // operand values leaning toward the edges
   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {8'($urandom_range(0, 255)), 8'hFF};
         3: return {8'($urandom_range(0, 255)), 8'h00};
         4: return {8'($urandom_range(0, 255)), 8'h0F};
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // request driver: next beat only once the current one is taken
   always @(posedge clock) begin
      req_data_type it;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_req_q.size() != 0 &&
             $urandom_range(0, 99) >= sender_gap_pct(accepted_count)) begin
            it = pending_req_q.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.op        <= it.op;
            req_bus.operand_a <= it.operand_a;
            req_bus.operand_b <= it.operand_b;
            req_bus.flags_in  <= it.flags_in;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= $urandom_range(0, 99) >= receiver_stall_pct(accepted_count);
      end
   end

   // monitor: predict on each request beat, check each response beat
   always @(posedge clock) begin
      req_data_type seen;
      rsp_data_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.op        = req_bus.op;
            seen.operand_a = req_bus.operand_a;
            seen.operand_b = req_bus.operand_b;
            seen.flags_in  = req_bus.flags_in;
            expected_rsp_q.push_back(alu_expect(seen));
            accepted_count++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected beat result", int'(rsp_bus.result), 0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_bus.result !== want.result)
                  report_mismatch("result", int'(rsp_bus.result), int'(want.result));
               if (rsp_bus.flags_out !== want.flags_out)
                  report_mismatch("flags_out", int'(rsp_bus.flags_out),
                                  int'(want.flags_out));
               if (rsp_bus.write_back !== want.write_back)
                  report_mismatch("write_back", int'(rsp_bus.write_back),
                                  int'(want.write_back));
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      req_data_type pre;
      rsp_data_type pre_rsp;
      logic [4:0] op;
      int pick;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = '0;
      req_bus.operand_a = '0;
      req_bus.operand_b = '0;
      req_bus.flags_in = '0;
      rsp_bus.ready = 1'b0;

      // directed: edges of most operations, high bytes ignored for 8-bit ops
      add_item(OP_ADD,   16'hA5FF, 16'h5A01, 4'b0000);
      add_item(OP_ADC,   16'h000F, 16'h0000, 4'b0001);
      add_item(OP_SUB,   16'h0000, 16'h0001, 4'b0000);
      add_item(OP_SBC,   16'h0010, 16'h000F, 4'b0001);
      add_item(OP_CP,    16'hFF42, 16'h0042, 4'b0000);
      add_item(OP_AND,   16'h00F0, 16'hFF0F, 4'b1111);
      add_item(OP_XOR,   16'h00FF, 16'h00FF, 4'b0000);
      add_item(OP_INC8,  16'h00FF, 16'h0000, 4'b0001);
      add_item(OP_DEC8,  16'h0000, 16'h0000, 4'b0000);
      add_item(OP_DAA,   16'h009A, 16'h0000, 4'b0000);
      add_item(OP_DAA,   16'h00FA, 16'h0000, 4'b0111);
      add_item(OP_DAA,   16'h000F, 16'h0000, 4'b0010);
      add_item(OP_CPL,   16'h005A, 16'h0000, 4'b1000);
      add_item(OP_SCF,   16'h0033, 16'h0000, 4'b1110);
      add_item(OP_CCF,   16'h0033, 16'h0000, 4'b0001);
      add_item(OP_RLCA,  16'h0080, 16'h0000, 4'b1000);
      add_item(OP_RRCA,  16'h0001, 16'h0000, 4'b0000);
      add_item(OP_ADD16, 16'hFFFF, 16'h0001, 4'b1000);
      add_item(OP_ADD_SP, 16'h00FF, 16'h0001, 4'b1111);
      add_item(OP_ADD_SP, 16'h1000, 16'hFF80, 4'b0000);
      add_item(OP_CB,    16'h007F, {8'hFF, CB_BIT, 3'd7, 3'd3}, 4'b0001);
      add_item(OP_CB,    16'h00FF, {8'h00, CB_RES, 3'd0, 3'd7}, 4'b0101);
      add_item(OP_CB,    16'h0000, {8'h00, CB_SET, 3'd7, 3'd0}, 4'b0000);
      add_item(OP_CB,    16'h00F0, {8'h00, CB_SHIFT, CB_SWAP, 3'd2}, 4'b0001);
      add_item(OP_INC16, 16'hFFFF, 16'h0000, 4'b1010);
      add_item(OP_DEC16, 16'h0000, 16'h0000, 4'b0101);
      add_item(OP_UNDEF_LO, 16'h1234, 16'h5678, 4'b1001);
      add_item(OP_UNDEF_HI, 16'hFFFF, 16'hFFFF, 4'b0110);

      // random part; some decimal adjusts follow a real bcd add or subtract
      while (pending_req_q.size() < RANDOM_LEN + 28) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            op = 5'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
            add_item(op, pick_operand(), pick_operand(), 4'($urandom_range(0, 15)));
         end else if (pick < 15) begin
            pre.op = 5'($urandom_range(OP_ADD, OP_SBC));
            pre.operand_a = {8'($urandom_range(0, 255)), 4'($urandom_range(0, 9)),
                             4'($urandom_range(0, 9))};
            pre.operand_b = {8'($urandom_range(0, 255)), 4'($urandom_range(0, 9)),
                             4'($urandom_range(0, 9))};
            pre.flags_in = 4'($urandom_range(0, 15));
            pre_rsp = alu_expect(pre);
            pending_req_q.push_back(pre);
            add_item(OP_DAA, {8'($urandom_range(0, 255)), pre_rsp.result[7:0]},
                     pick_operand(), pre_rsp.flags_out);
         end else begin
            op = 5'($urandom_range(OP_ADD, OP_DEC16));
            add_item(op, pick_operand(), pick_operand(), 4'($urandom_range(0, 15)));
         end
      end
      total_items = pending_req_q.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != total_items || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
